// ----- design/b64u_pkg.sv -----
// Package for the base64url padded encoder: payload structs, queue entry type,
// queue depth default and the 6-bit to ASCII alphabet mapping. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64u_pkg;

	// Input transaction payload
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// Output transaction payload
	typedef struct packed {
		logic [7:0] char_out;
		logic       last_char;
	} out_item_t;

	// One closed group handed from front to back
	typedef struct packed {
		logic [23:0] group;
		logic [1:0]  nbytes;  // 1..3 real bytes in the group
		logic        last;
	} grp_t;

	// Back-end status seen by the top level
	typedef struct packed {
		logic       ent_vld;
		logic [1:0] out_idx;
	} bk_stat_t;

	localparam int B64U_QUEUE_DEPTH = 2;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Map a 6-bit group to the URL-safe alphabet
	function automatic logic [7:0] b64u_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 8'h2D;
		end else begin
			c = 8'h5F;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- design/b64u_front.sv -----
// Front end of the base64url encoder: accepts bytes, keeps the open group and
// pushes each closed group into the queue. Depends on b64u_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64u_front
	import b64u_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     src_valid,
	output logic          src_ready,
	input  wire in_item_t src_data,
	input  wire logic     q_full,
	output logic          q_push,
	output grp_t          q_wdata
);

	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic        accept;
	logic        close;

	assign src_ready = !q_full;
	assign accept    = src_valid && src_ready;
	// a count of three is treated like two
	assign close     = src_data.last_byte || cnt_q[1];
	assign q_push    = accept && close;

	// build the closed group, zero-filled
	always_comb begin
		q_wdata.last = src_data.last_byte;
		case (cnt_q)
			2'd0: begin
				q_wdata.group  = {src_data.data_byte, 16'h0000};
				q_wdata.nbytes = 2'd1;
			end
			2'd1: begin
				q_wdata.group  = {pend_q[15:8], src_data.data_byte, 8'h00};
				q_wdata.nbytes = 2'd2;
			end
			default: begin
				q_wdata.group  = {pend_q, src_data.data_byte};
				q_wdata.nbytes = 2'd3;
			end
		endcase
	end

	// hold pending bytes and advance the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			pend_q <= 16'h0000;
		end else if (accept) begin
			if (close) begin
				cnt_q  <= 2'd0;
				pend_q <= 16'h0000;
			end else begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd0) begin
					pend_q <= {src_data.data_byte, 8'h00};
				end else begin
					pend_q <= {pend_q[15:8], src_data.data_byte};
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/b64u_fifo.sv -----
// Small queue of closed groups between front and back of the encoder.
// Depends on b64u_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64u_fifo
	import b64u_pkg::*;
#(
	parameter int DEPTH = B64U_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire grp_t wdata,
	output logic      full,
	input  wire logic pop,
	output logic      rd_vld,
	output grp_t      rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	grp_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign rd_vld  = (cnt_q != '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && rd_vld;

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/b64u_back.sv -----
// Back end of the base64url encoder: takes one group from the queue and sends
// its four characters through a registered output stage. Depends on b64u_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64u_back
	import b64u_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_vld,
	input  wire grp_t q_rdata,
	output logic      q_pop,
	output logic      dst_valid,
	input  wire logic dst_ready,
	output out_item_t dst_data,
	output bk_stat_t  stat
);

	grp_t       ent_q;
	logic       ent_vld_q;
	logic [1:0] idx_q;
	logic       out_vld_q;
	out_item_t  out_q;
	logic [1:0] oidx_q;
	logic       load_out;
	logic       done_ent;
	logic [5:0] sext;
	out_item_t  nxt;

	assign load_out = ent_vld_q && (!out_vld_q || dst_ready);
	assign done_ent = load_out && (idx_q == 2'd3);
	assign q_pop    = q_vld && (!ent_vld_q || done_ent);

	// pick the 6-bit slice, most significant first
	always_comb begin
		case (idx_q)
			2'd0:    sext = ent_q.group[23:18];
			2'd1:    sext = ent_q.group[17:12];
			2'd2:    sext = ent_q.group[11:6];
			default: sext = ent_q.group[5:0];
		endcase
		nxt.char_out  = (idx_q > ent_q.nbytes) ? PAD_CHAR : b64u_char(sext);
		nxt.last_char = (idx_q == 2'd3) && ent_q.last;
	end

	// hold the current group and step through its characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
			idx_q     <= 2'd0;
		end else if (q_pop) begin
			ent_vld_q <= 1'b1;
			idx_q     <= 2'd0;
		end else begin
			if (done_ent) begin
				ent_vld_q <= 1'b0;
			end
			if (load_out) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			oidx_q    <= 2'd0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
			oidx_q    <= idx_q;
		end else if (dst_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= nxt;
		end
	end

	assign dst_valid    = out_vld_q;
	assign dst_data     = out_q;
	assign stat.ent_vld = ent_vld_q;
	assign stat.out_idx = oidx_q;

endmodule

`default_nettype wire

// ----- design/base64url_padded_encoder_top.sv -----
// Base64url encoder with padding: top level joining front end, group queue and
// back end. Depends on b64u_pkg, b64u_front, b64u_fifo, b64u_back.
//
// Usage:
//   src channel (src_valid/src_ready/src_data) takes one raw byte per
//   transaction, with last_byte marking the end of a message.
//   dst channel (dst_valid/dst_ready/dst_data) gives one ASCII character per
//   transaction; last_char marks the final character of a message.
//   Every third byte, or a byte with last_byte set, closes a group that yields
//   four characters; a one- or two-byte tail ends in "==" or "=".
// Path: a closing byte pushes its group into the queue; the back end takes the
//   group into its group register and loads each character into the output register.
// Throughput: the back end sends one character per cycle while a group is held
//   and the receiver is ready, four characters per group. Bytes that do not
//   close a group are also held off while the queue of QUEUE_DEPTH groups is
//   full; the queue absorbs bursts.
// Reset clears the pending group, the queue and the output stage.
// When the receiver stalls, the output register holds its character; the
// front keeps accepting bytes until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module base64url_padded_encoder_top
	import b64u_pkg::*;
#(
	parameter int QUEUE_DEPTH = B64U_QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     src_valid,
	output logic          src_ready,
	input  wire in_item_t src_data,
	output logic          dst_valid,
	input  wire logic     dst_ready,
	output out_item_t     dst_data
);

	logic     q_full;
	logic     q_push;
	grp_t     q_wdata;
	logic     q_pop;
	logic     q_vld;
	grp_t     q_rdata;
	bk_stat_t stat;

	b64u_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	b64u_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rd_vld (q_vld),
		.rdata  (q_rdata)
	);

	b64u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_vld     (q_vld),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.stat      (stat)
	);

`ifndef SYNTHESIS
	// a closed group is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("group pushed into full queue");

	// the last-character flag only rides on the fourth character of a group
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_data.last_char) |-> (stat.out_idx == 2'd3))
		else $error("last_char on wrong position");

	// padding only appears in the third or fourth position
	a_pad_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_data.char_out == PAD_CHAR) |-> stat.out_idx[1])
		else $error("padding in first or second position");

	// an idle back end picks up a waiting group in the next cycle
	a_pickup: assert property (@(posedge clk) disable iff (!arst_n)
		(q_vld && !stat.ent_vld) |=> stat.ent_vld)
		else $error("waiting group not picked up");
`endif

endmodule

`default_nettype wire
